// File: hw/rtl/frq_pkg.sv
// Shared types, codes and constants for the frame ring queue.
`default_nettype none

package frq_pkg;

  // Default values for the top-level parameters.
  localparam int DEF_MAX_FRAME_BYTES = 1024;
  localparam int DEF_DEFAULT_DEPTH   = 16;

  // Ring geometry: at most DEPTH_CAP frames, plus one slot that stays empty.
  localparam int DEPTH_CAP   = 16;
  localparam int STORE_SLOTS = DEPTH_CAP + 1;
  localparam int SLOT_W      = 5;

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int FB_W     = 11;
  localparam int QD_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_LEN_ERR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_DEPTH = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;     // An input item is transferred this cycle.
    logic rd_load;  // Store read data is ready to load into the output register.
    logic cfg_we;   // A configuration write is transferred this cycle.
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/frq_ctrl.sv
// Controller state machine: handshakes and sequencing of store reads.
`default_nettype none

module frq_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [frq_pkg::CMD_W-1:0] in_cmd,
  output logic                           in_ready,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  output frq_pkg::ctrl_cmd_t             ctrl
);
  import frq_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_RDWAIT = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_xfer;
  logic is_read;

  // An item is taken only when the output register is free or is emptied now.
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid && (!out_valid_r || out_ready);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_xfer   = in_valid && in_ready;
  assign is_read   = (in_cmd == CMD_READ);

  // Datapath commands.
  assign ctrl.exec    = in_xfer;
  assign ctrl.rd_load = (state_r == ST_RDWAIT);
  assign ctrl.cfg_we  = cfg_valid && cfg_ready;

  // Next state and output valid.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (is_read) begin
            state_nxt = ST_RDWAIT;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_RDWAIT: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/frq_datapath.sv
// Datapath: ring pointers, frame store, configuration and output registers.
`default_nettype none

module frq_datapath #(
  parameter int MAX_FRAME_BYTES = frq_pkg::DEF_MAX_FRAME_BYTES,
  parameter int DEFAULT_DEPTH   = frq_pkg::DEF_DEFAULT_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire frq_pkg::ctrl_cmd_t             ctrl,
  input  wire logic [frq_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [frq_pkg::BYTE_W-1:0]     in_data_in,
  input  wire logic                           in_push_last,
  input  wire logic [frq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [frq_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [frq_pkg::BYTE_W-1:0]          out_data_out,
  output logic [frq_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_dropped_oldest,
  output logic                                out_frame_end,
  output logic [frq_pkg::COUNT_W-1:0]         out_count
);
  import frq_pkg::*;

  // Byte position widths and the store geometry.
  localparam int AW      = $clog2(MAX_FRAME_BYTES);
  localparam int WPW     = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LW      = (WPW > FB_W) ? WPW : FB_W;
  localparam int MEM_W   = SLOT_W + AW;
  localparam int MEM_D   = STORE_SLOTS << AW;
  localparam int DEF_EFF = (DEFAULT_DEPTH > DEPTH_CAP) ? DEPTH_CAP : DEFAULT_DEPTH;
  localparam logic [LW-1:0]     MAX_L    = LW'(MAX_FRAME_BYTES);
  localparam logic [WPW-1:0]    MAX_W    = WPW'(MAX_FRAME_BYTES);
  localparam logic [SLOT_W-1:0] CAP_S    = SLOT_W'(DEPTH_CAP);
  localparam logic [SLOT_W-1:0] DEF_S    = SLOT_W'(DEF_EFF);

  // Next ring slot, wrapping at the slot count.
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                  input logic [SLOT_W-1:0] n_slots);
    logic [SLOT_W-1:0] n;
    n = s + SLOT_W'(1);
    return (n >= n_slots) ? '0 : n;
  endfunction

  // Frames held between head and tail.
  function automatic logic [SLOT_W-1:0] held(input logic [SLOT_W-1:0] t,
                                             input logic [SLOT_W-1:0] h,
                                             input logic [SLOT_W-1:0] n_slots);
    logic [SLOT_W:0] wrap;
    wrap = {1'b0, t} + {1'b0, n_slots} - {1'b0, h};
    return (t >= h) ? (t - h) : wrap[SLOT_W-1:0];
  endfunction

  logic [FB_W-1:0]   frame_bytes_r, frame_bytes_nxt;
  logic [QD_W-1:0]   queue_depth_r, queue_depth_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [WPW-1:0]    wpos_r, wpos_nxt;
  logic [AW-1:0]     rpos_r, rpos_nxt;
  logic              ovf_r, ovf_nxt;

  logic [BYTE_W-1:0]   mem [MEM_D];
  logic [BYTE_W-1:0]   mem_q_r;
  logic                rd_hit_r, rd_hit_nxt;

  logic [BYTE_W-1:0]   data_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                dropped_r, dropped_nxt;
  logic                fend_r, fend_nxt;
  logic [COUNT_W-1:0]  count_r;

  logic [SLOT_W-1:0] depth_eff;
  logic [SLOT_W-1:0] n_slots;
  logic [LW-1:0]     fb_ext;
  logic [LW-1:0]     rd_len;
  logic              wr_room;
  logic [WPW-1:0]    wpos_after;
  logic              frame_ok;
  logic [AW-1:0]     rpos_eff;
  logic [LW-1:0]     rpos_step;
  logic              mem_we;
  logic              mem_re;
  logic [MEM_W-1:0]  wr_addr;
  logic [MEM_W-1:0]  rd_addr;

  // Effective depth and ring size.
  assign depth_eff = (queue_depth_r == '0) ? DEF_S
                   : ((queue_depth_r > CAP_S) ? CAP_S : queue_depth_r);
  assign n_slots   = depth_eff + SLOT_W'(1);

  // Read length clamped to one up to the slot size.
  assign fb_ext = LW'(frame_bytes_r);
  assign rd_len = (fb_ext == '0) ? LW'(1) : ((fb_ext > MAX_L) ? MAX_L : fb_ext);

  // Push bookkeeping.
  assign wr_room    = (wpos_r < MAX_W);
  assign wpos_after = wr_room ? (wpos_r + WPW'(1)) : wpos_r;
  assign frame_ok   = !ovf_r && wr_room && (LW'(wpos_after) == fb_ext);

  // Read position, restarted if it lies beyond the frame.
  assign rpos_eff  = (LW'(rpos_r) >= rd_len) ? '0 : rpos_r;
  assign rpos_step = LW'(rpos_eff) + LW'(1);

  // Store addresses: slot in the upper bits, byte position in the lower.
  assign wr_addr = {tail_r, wpos_r[AW-1:0]};
  assign rd_addr = {head_r, rpos_eff};
  assign mem_we  = ctrl.exec && (in_cmd == CMD_PUSH) && wr_room;
  assign mem_re  = ctrl.exec && (in_cmd == CMD_READ);

  // Command execution and configuration writes.
  always_comb begin
    frame_bytes_nxt = frame_bytes_r;
    queue_depth_nxt = queue_depth_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    wpos_nxt        = wpos_r;
    rpos_nxt        = rpos_r;
    ovf_nxt         = ovf_r;
    rd_hit_nxt      = rd_hit_r;
    status_nxt      = STAT_OK;
    dropped_nxt     = 1'b0;
    fend_nxt        = 1'b0;
    if (ctrl.cfg_we) begin
      // Either register write also empties the queue.
      if (cfg_index == CFG_FRAME_BYTES || cfg_index == CFG_QUEUE_DEPTH) begin
        if (cfg_index == CFG_FRAME_BYTES) begin
          frame_bytes_nxt = cfg_data[FB_W-1:0];
        end else begin
          queue_depth_nxt = cfg_data[QD_W-1:0];
        end
        head_nxt = '0;
        tail_nxt = '0;
        wpos_nxt = '0;
        rpos_nxt = '0;
        ovf_nxt  = 1'b0;
      end
    end else if (ctrl.exec) begin
      rd_hit_nxt = 1'b0;
      case (in_cmd)
        CMD_PUSH: begin
          wpos_nxt = wpos_after;
          if (!wr_room) begin
            ovf_nxt = 1'b1;
          end
          if (in_push_last) begin
            if (frame_ok) begin
              // A full ring drops its oldest frame to make room.
              if (slot_inc(tail_r, n_slots) == head_r) begin
                head_nxt    = slot_inc(head_r, n_slots);
                rpos_nxt    = '0;
                dropped_nxt = 1'b1;
              end
              tail_nxt = slot_inc(tail_r, n_slots);
            end else begin
              status_nxt = STAT_LEN_ERR;
            end
            wpos_nxt = '0;
            ovf_nxt  = 1'b0;
          end
        end
        CMD_READ: begin
          if (held(tail_r, head_r, n_slots) == '0) begin
            status_nxt = STAT_EMPTY;
          end else begin
            rd_hit_nxt = 1'b1;
            if (rpos_step >= rd_len) begin
              fend_nxt = 1'b1;
              rpos_nxt = '0;
              head_nxt = slot_inc(head_r, n_slots);
            end else begin
              rpos_nxt = rpos_step[AW-1:0];
            end
          end
        end
        CMD_CLEAR: begin
          head_nxt = '0;
          tail_nxt = '0;
          wpos_nxt = '0;
          rpos_nxt = '0;
          ovf_nxt  = 1'b0;
        end
        default: begin
          // Query changes no state.
        end
      endcase
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bytes_r <= FB_W'(1);
      queue_depth_r <= '0;
      head_r        <= '0;
      tail_r        <= '0;
      wpos_r        <= '0;
      rpos_r        <= '0;
      ovf_r         <= 1'b0;
      rd_hit_r      <= 1'b0;
    end else begin
      frame_bytes_r <= frame_bytes_nxt;
      queue_depth_r <= queue_depth_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      wpos_r        <= wpos_nxt;
      rpos_r        <= rpos_nxt;
      ovf_r         <= ovf_nxt;
      rd_hit_r      <= rd_hit_nxt;
    end
  end

  // Frame store write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_data_in;
    end
  end

  // Frame store read port with registered data.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Output payload registers; the read byte lands in the cycle after the others.
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      data_r    <= '0;
      status_r  <= status_nxt;
      dropped_r <= dropped_nxt;
      fend_r    <= fend_nxt;
      count_r   <= COUNT_W'(held(tail_nxt, head_nxt, n_slots));
    end else if (ctrl.rd_load) begin
      data_r <= rd_hit_r ? mem_q_r : '0;
    end
  end

  assign out_data_out       = data_r;
  assign out_status         = status_r;
  assign out_dropped_oldest = dropped_r;
  assign out_frame_end      = fend_r;
  assign out_count          = count_r;

endmodule

`default_nettype wire

// File: hw/rtl/frame_ring_queue_drop_oldest_unit.sv
// Top level of the frame ring queue that drops its oldest frame when full.
// Push, clear and query results are valid in the cycle after the transfer; a read result
// is valid after the read-wait state; new items wait until it is presented.
// Throughput: one push, clear or query per cycle unless held by out_ready or cfg_valid.
// Reset clears pointers, byte positions and configuration (frame_bytes 1, depth 0).
// Frame store contents are undefined after reset; no clearing pass is run.
`default_nettype none

module frame_ring_queue_drop_oldest_unit #(
  parameter int MAX_FRAME_BYTES = frq_pkg::DEF_MAX_FRAME_BYTES,
  parameter int DEFAULT_DEPTH   = frq_pkg::DEF_DEFAULT_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [frq_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [frq_pkg::BYTE_W-1:0]     in_data_in,
  input  wire logic                           in_push_last,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [frq_pkg::BYTE_W-1:0]          out_data_out,
  output logic [frq_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_dropped_oldest,
  output logic                                out_frame_end,
  output logic [frq_pkg::COUNT_W-1:0]         out_count,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [frq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [frq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import frq_pkg::*;

  ctrl_cmd_t ctrl;

  // Controller.
  frq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .ctrl      (ctrl)
  );

  // Datapath.
  frq_datapath #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .DEFAULT_DEPTH   (DEFAULT_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .in_cmd             (in_cmd),
    .in_data_in         (in_data_in),
    .in_push_last       (in_push_last),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_data_out       (out_data_out),
    .out_status         (out_status),
    .out_dropped_oldest (out_dropped_oldest),
    .out_frame_end      (out_frame_end),
    .out_count          (out_count)
  );

  // A read transfer waits in the read-wait state for the store, then presents its result.
  a_read_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == CMD_READ) |=>
      (!in_ready && !out_valid) ##1 out_valid)
    else $error("read result timing violated");

  // An empty read returns no byte and no frame end.
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_EMPTY) |-> (out_data_out == '0 && !out_frame_end))
    else $error("empty read carries data");

  // A drop happens only on a successful commit.
  a_drop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped_oldest) |-> (out_status == STAT_OK && !out_frame_end))
    else $error("drop flagged on a failed commit");

  // The ring never reports more frames than its cap.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= COUNT_W'(DEPTH_CAP)))
    else $error("frame count above cap");

endmodule

`default_nettype wire
